[rtl/core/dfu_pkg.sv]
// Shared codes, types and constants for the DFU download sequencer.
`default_nettype none

package dfu_pkg;

    localparam int FIELD_W         = 24;
    localparam int BLKNUM_W        = 16;
    localparam int DEF_BLOCK_BYTES = 1024;

    // Response codes on the command field
    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_STATE  = 3'd1;
    localparam logic [2:0] CMD_STATUS = 3'd2;
    localparam logic [2:0] CMD_ACK    = 3'd3;
    localparam logic [2:0] CMD_WAITED = 3'd4;
    localparam logic [2:0] CMD_BAD    = 3'd7;

    // Request codes on the action field
    localparam logic [2:0] ACT_STATE  = 3'd0;
    localparam logic [2:0] ACT_STATUS = 3'd1;
    localparam logic [2:0] ACT_DNLOAD = 3'd2;
    localparam logic [2:0] ACT_WAIT   = 3'd3;
    localparam logic [2:0] ACT_DONE   = 3'd4;
    localparam logic [2:0] ACT_ERROR  = 3'd5;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_EMPTY  = 3'd1;
    localparam logic [2:0] ERR_XFER   = 3'd2;
    localparam logic [2:0] ERR_DEVICE = 3'd3;
    localparam logic [2:0] ERR_UNSUP  = 3'd4;
    localparam logic [2:0] ERR_UNEXP  = 3'd5;

    // Device state bytes
    localparam logic [7:0] DST_DNLOAD_SYNC = 8'h02;
    localparam logic [7:0] DST_DNBUSY      = 8'h03;
    localparam logic [7:0] DST_DNBUSY_WAIT = 8'h04;
    localparam logic [7:0] DST_DNLOAD_IDLE = 8'h05;
    localparam logic [7:0] DST_MANIF_SYNC  = 8'h06;
    localparam logic [7:0] DST_MANIFEST    = 8'h07;
    localparam logic [7:0] DST_MANIF_WAIT  = 8'h08;
    localparam logic [7:0] DST_UPLOAD_IDLE = 8'h09;
    localparam logic [7:0] DST_ERROR       = 8'h0a;

    // Reaction class of a device state
    localparam logic [2:0] CLS_UNSUP     = 3'd0;
    localparam logic [2:0] CLS_DNLOAD    = 3'd1;
    localparam logic [2:0] CLS_STATUS_DL = 3'd2;
    localparam logic [2:0] CLS_STATUS_MN = 3'd3;
    localparam logic [2:0] CLS_WAIT      = 3'd4;
    localparam logic [2:0] CLS_DONE      = 3'd5;
    localparam logic [2:0] CLS_DEVERR    = 3'd6;

    typedef struct packed {
        logic [2:0]         kind;
        logic               ok;
        logic [2:0]         st_class;
        logic [FIELD_W-1:0] timeout;
    } entry_t;

endpackage

`default_nettype wire

[rtl/core/dfu_host_download_sequencer.sv]
// Top level of the host-side DFU firmware download sequencer.
`default_nettype none

// Usage
//   Device responses enter on the request channel (push/full) as command,
//   transfer_ok, device_state and poll_timeout. For each accepted request the
//   block emits exactly one next host request on the result channel
//   (empty/pop): action plus block_number/block_offset/block_length for a
//   download, wait_ms for a wait, error_code for an error.
//   The image length is set over the APB port at address 0 before a start.
// Pipeline and throughput
//   An accepted request is classified by the front stage and parked in a
//   two-entry queue; the back stage takes it from there and writes its
//   result into the output queue that drives the output ports. One request
//   per cycle is sustained while pop keeps the output queue from filling:
//   the back stage state update is one compare, one subtract and two adds.
// Reset
//   rst_n clears both queues and puts the sequencer in idle awaiting start.
// Stalls
//   When pop stays low the output queue fills, the back stage holds, the
//   middle queue fills and full rises; no request is dropped.
module dfu_host_download_sequencer #(
    parameter int BLOCK_BYTES = dfu_pkg::DEF_BLOCK_BYTES,
    parameter int LEN_W       = $clog2(BLOCK_BYTES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [2:0]                   command,
    input  wire logic                         transfer_ok,
    input  wire logic [7:0]                   device_state,
    input  wire logic [dfu_pkg::FIELD_W-1:0]  poll_timeout,
    // result channel
    output logic                              empty,
    input  wire logic                         pop,
    output logic [2:0]                        action,
    output logic [dfu_pkg::BLKNUM_W-1:0]      block_number,
    output logic [dfu_pkg::FIELD_W-1:0]       block_offset,
    output logic [LEN_W-1:0]                  block_length,
    output logic [dfu_pkg::FIELD_W-1:0]       wait_ms,
    output logic [2:0]                        error_code,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dfu_pkg::*;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int RES_W   = 3 + BLKNUM_W + FIELD_W + LEN_W + FIELD_W + 3;

    logic [FIELD_W-1:0]  image_length_reg;
    logic                cfg_wr;

    entry_t              front_entry;
    entry_t              mid_entry;
    logic [ENTRY_W-1:0]  mid_rdata;
    logic                mid_empty;

    logic                back_fire;
    logic                res_full;
    logic [2:0]          r_action;
    logic [BLKNUM_W-1:0] r_block_number;
    logic [FIELD_W-1:0]  r_block_offset;
    logic [LEN_W-1:0]    r_block_length;
    logic [FIELD_W-1:0]  r_wait_ms;
    logic [2:0]          r_error_code;
    logic [RES_W-1:0]    res_wdata;
    logic [RES_W-1:0]    res_rdata;

    // APB register: image length, one word, selected when paddr[2] is low
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(image_length_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= '0;
        end
        else if (cfg_wr)
        begin
            image_length_reg <= pwdata[FIELD_W-1:0];
        end
    end

    // Front: classify the response
    dfu_front u_front (
        .command      (command),
        .transfer_ok  (transfer_ok),
        .device_state (device_state),
        .poll_timeout (poll_timeout),
        .entry        (front_entry)
    );

    // Queue between front and back
    dfu_queue #(
        .WIDTH (ENTRY_W)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_entry),
        .full  (full),
        .pop   (back_fire),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_entry = entry_t'(mid_rdata);

    // Back: advance the download state machine
    dfu_back #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .LEN_W       (LEN_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .image_length     (image_length_reg),
        .entry            (mid_entry),
        .entry_valid      (!mid_empty),
        .res_full         (res_full),
        .fire             (back_fire),
        .res_action       (r_action),
        .res_block_number (r_block_number),
        .res_block_offset (r_block_offset),
        .res_block_length (r_block_length),
        .res_wait_ms      (r_wait_ms),
        .res_error_code   (r_error_code)
    );

    assign res_wdata = {r_action, r_block_number, r_block_offset,
                        r_block_length, r_wait_ms, r_error_code};

    // Output queue: holds finished requests while the receiver stalls
    dfu_queue #(
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_fire),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign {action, block_number, block_offset, block_length, wait_ms, error_code} = res_rdata;

endmodule

`default_nettype wire

[rtl/core/dfu_queue.sv]
// Two-entry first-in first-out queue used between the sequencer stages.
`default_nettype none

module dfu_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> !empty)
        else $error("queue empty after write");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/core/dfu_front.sv]
// Front stage: sorts a device response into a command kind and a state class.
`default_nettype none

module dfu_front (
    input  wire logic [2:0]                  command,
    input  wire logic                        transfer_ok,
    input  wire logic [7:0]                  device_state,
    input  wire logic [dfu_pkg::FIELD_W-1:0] poll_timeout,
    output dfu_pkg::entry_t                  entry
);
    import dfu_pkg::*;

    logic [2:0] kind;
    logic [2:0] st_class;

    always_comb
    begin
        case (command)
            CMD_START, CMD_STATE, CMD_STATUS, CMD_ACK, CMD_WAITED: kind = command;
            default: kind = CMD_BAD;
        endcase
    end

    always_comb
    begin
        case (device_state)
            DST_DNLOAD_SYNC, DST_DNLOAD_IDLE: st_class = CLS_DNLOAD;
            DST_DNBUSY:                       st_class = CLS_STATUS_DL;
            DST_MANIF_SYNC:                   st_class = CLS_STATUS_MN;
            DST_DNBUSY_WAIT:                  st_class = CLS_WAIT;
            DST_MANIFEST, DST_MANIF_WAIT:     st_class = CLS_DONE;
            DST_ERROR:                        st_class = CLS_DEVERR;
            // upload idle is not handled by this sequencer
            DST_UPLOAD_IDLE:                  st_class = CLS_UNSUP;
            default:                          st_class = CLS_UNSUP;
        endcase
    end

    assign entry.kind     = kind;
    assign entry.ok       = transfer_ok;
    assign entry.st_class = st_class;
    assign entry.timeout  = poll_timeout;

endmodule

`default_nettype wire

[rtl/core/dfu_back.sv]
// Back stage: download state machine that turns classified responses into requests.
`default_nettype none

module dfu_back #(
    parameter int BLOCK_BYTES = dfu_pkg::DEF_BLOCK_BYTES,
    parameter int LEN_W       = $clog2(BLOCK_BYTES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [dfu_pkg::FIELD_W-1:0]  image_length,
    input  wire dfu_pkg::entry_t              entry,
    input  wire logic                         entry_valid,
    input  wire logic                         res_full,
    output logic                              fire,
    output logic [2:0]                        res_action,
    output logic [dfu_pkg::BLKNUM_W-1:0]      res_block_number,
    output logic [dfu_pkg::FIELD_W-1:0]       res_block_offset,
    output logic [LEN_W-1:0]                  res_block_length,
    output logic [dfu_pkg::FIELD_W-1:0]       res_wait_ms,
    output logic [2:0]                        res_error_code
);
    import dfu_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_STATE      = 3'd1;
    localparam logic [2:0] PH_STATUS_DL  = 3'd2;
    localparam logic [2:0] PH_STATUS_MAN = 3'd3;
    localparam logic [2:0] PH_ACK        = 3'd4;
    localparam logic [2:0] PH_WAIT_STATE = 3'd5;
    localparam logic [2:0] PH_WAIT_ACT   = 3'd6;
    localparam logic [2:0] PH_STOP       = 3'd7;

    localparam logic [FIELD_W-1:0] BLOCK_SIZE = FIELD_W'(BLOCK_BYTES);

    logic [2:0]          phase_reg, phase_next;
    logic [2:0]          cls_reg, cls_next;
    logic [FIELD_W-1:0]  tmo_reg, tmo_next;
    logic [FIELD_W-1:0]  rem_reg, rem_next;
    logic [FIELD_W-1:0]  off_reg, off_next;
    logic [BLKNUM_W-1:0] blk_reg, blk_next;

    logic                do_act;
    logic [2:0]          act_cls;
    logic                do_fail;
    logic [2:0]          fail_code;
    logic [LEN_W-1:0]    len;
    logic [FIELD_W-1:0]  len_wide;

    assign fire = entry_valid && !res_full;

    // next block length: a full block, or whatever is left
    always_comb
    begin
        if (rem_reg <= BLOCK_SIZE)
        begin
            len = rem_reg[LEN_W-1:0];
        end
        else
        begin
            len = BLOCK_SIZE[LEN_W-1:0];
        end
    end
    assign len_wide = FIELD_W'(len);

    always_comb
    begin
        phase_next       = phase_reg;
        cls_next         = cls_reg;
        tmo_next         = tmo_reg;
        rem_next         = rem_reg;
        off_next         = off_reg;
        blk_next         = blk_reg;
        do_act           = 1'b0;
        act_cls          = cls_reg;
        do_fail          = 1'b0;
        fail_code        = ERR_UNEXP;
        res_action       = ACT_STATE;
        res_block_number = '0;
        res_block_offset = '0;
        res_block_length = '0;
        res_wait_ms      = '0;
        res_error_code   = ERR_NONE;

        case (entry.kind)
            CMD_START:
            begin
                cls_next = CLS_UNSUP;
                tmo_next = '0;
                off_next = '0;
                blk_next = '0;
                rem_next = image_length;
                if (image_length == '0)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_EMPTY;
                end
                else
                begin
                    res_action = ACT_STATE;
                    phase_next = PH_STATE;
                end
            end
            CMD_STATE:
            begin
                if (phase_reg != PH_STATE)
                begin
                    do_fail = 1'b1;
                end
                else if (!entry.ok)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_XFER;
                end
                else
                begin
                    cls_next = entry.st_class;
                    act_cls  = entry.st_class;
                    do_act   = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                if (phase_reg != PH_STATUS_DL && phase_reg != PH_STATUS_MAN)
                begin
                    do_fail = 1'b1;
                end
                else if (!entry.ok)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_XFER;
                end
                else
                begin
                    cls_next = entry.st_class;
                    tmo_next = entry.timeout;
                    if (phase_reg == PH_STATUS_DL)
                    begin
                        act_cls = entry.st_class;
                        do_act  = 1'b1;
                    end
                    else
                    begin
                        // manifest sync: always hold off for the poll timeout
                        res_action  = ACT_WAIT;
                        res_wait_ms = entry.timeout;
                        phase_next  = PH_WAIT_ACT;
                    end
                end
            end
            CMD_ACK:
            begin
                if (phase_reg != PH_ACK)
                begin
                    do_fail = 1'b1;
                end
                else if (!entry.ok)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_XFER;
                end
                else
                begin
                    res_action = ACT_STATE;
                    phase_next = PH_STATE;
                end
            end
            CMD_WAITED:
            begin
                if (phase_reg == PH_WAIT_STATE)
                begin
                    res_action = ACT_STATE;
                    phase_next = PH_STATE;
                end
                else if (phase_reg == PH_WAIT_ACT)
                begin
                    act_cls = cls_reg;
                    do_act  = 1'b1;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            default:
            begin
                do_fail = 1'b1;
            end
        endcase

        if (do_act)
        begin
            case (act_cls)
                CLS_DNLOAD:
                begin
                    res_action       = ACT_DNLOAD;
                    res_block_number = blk_reg;
                    res_block_offset = off_reg;
                    res_block_length = len;
                    rem_next         = rem_reg - len_wide;
                    off_next         = off_reg + len_wide;
                    blk_next         = blk_reg + BLKNUM_W'(1);
                    phase_next       = PH_ACK;
                end
                CLS_STATUS_DL:
                begin
                    res_action = ACT_STATUS;
                    phase_next = PH_STATUS_DL;
                end
                CLS_STATUS_MN:
                begin
                    res_action = ACT_STATUS;
                    phase_next = PH_STATUS_MAN;
                end
                CLS_WAIT:
                begin
                    res_action  = ACT_WAIT;
                    res_wait_ms = tmo_next;
                    phase_next  = PH_WAIT_STATE;
                end
                CLS_DONE:
                begin
                    res_action = ACT_DONE;
                    phase_next = PH_STOP;
                end
                CLS_DEVERR:
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_DEVICE;
                end
                default:
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNSUP;
                end
            endcase
        end

        if (do_fail)
        begin
            res_action       = ACT_ERROR;
            res_error_code   = fail_code;
            res_block_number = '0;
            res_block_offset = '0;
            res_block_length = '0;
            res_wait_ms      = '0;
            phase_next       = PH_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cls_reg   <= CLS_UNSUP;
            tmo_reg   <= '0;
            rem_reg   <= '0;
            off_reg   <= '0;
            blk_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            tmo_reg   <= tmo_next;
            rem_reg   <= rem_next;
            off_reg   <= off_next;
            blk_reg   <= blk_next;
        end
    end

    a_stop_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (res_action == ACT_DONE || res_action == ACT_ERROR)
        |=> phase_reg == PH_STOP)
        else $error("sequencer not stopped after done or error");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_action == ACT_DNLOAD |-> FIELD_W'(res_block_length) <= BLOCK_SIZE)
        else $error("download block longer than block size");

    a_dnload_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_action == ACT_DNLOAD
        |=> phase_reg == PH_ACK && blk_reg == $past(blk_reg) + BLKNUM_W'(1))
        else $error("download did not advance block counter");

endmodule

`default_nettype wire
